// ----- design/lprd_pkg.sv -----
// ----------------------------------------------------------------------------
// lprd_pkg
// Shared types and constants for the length-prefixed request deframer.
// ----------------------------------------------------------------------------
package lprd_pkg;

    localparam int BYTE_W        = 8;
    localparam int INDEX_W       = 13;
    localparam int LEN_FIELD_BYTES = 4;

    // First word of a recognized command, lower case, three bytes.
    localparam logic [23:0] FW_GET = 24'h676574;
    localparam logic [23:0] FW_SET = 24'h736574;
    localparam logic [23:0] FW_DEL = 24'h64656C;

    typedef enum logic [1:0] {
        KIND_WORD_BYTE  = 2'd0,
        KIND_FRAME_DONE = 2'd1,
        KIND_CLOSED     = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD      = 2'd1,
        STATUS_TOO_LONG = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CLS_GET     = 2'd0,
        CLS_SET     = 2'd1,
        CLS_DEL     = 2'd2,
        CLS_UNKNOWN = 2'd3
    } t_class;

    typedef struct packed {
        t_kind              kind;
        logic [BYTE_W-1:0]  data;
        logic [INDEX_W-1:0] index;
        logic               word_last;
        t_status            status;
        t_class             cls;
        logic               last_of_run;
    } t_result;

endpackage

// ----- design/lprd_in_if.sv -----
// ----------------------------------------------------------------------------
// lprd_in_if
// Request channel: one received byte per request, with a new-connection flag.
// ----------------------------------------------------------------------------
interface lprd_in_if;

    logic                       valid;
    logic                       ready;
    logic [lprd_pkg::BYTE_W-1:0] in_byte;
    logic                       new_connection;

    modport source (output valid, output in_byte, output new_connection, input ready);
    modport sink   (input valid, input in_byte, input new_connection, output ready);

endinterface

// ----- design/lprd_out_if.sv -----
// ----------------------------------------------------------------------------
// lprd_out_if
// Result channel: word bytes, frame-finished and connection-closed results.
// ----------------------------------------------------------------------------
interface lprd_out_if;

    logic                         valid;
    logic                         ready;
    logic [1:0]                   out_kind;
    logic [lprd_pkg::BYTE_W-1:0]  out_byte;
    logic [lprd_pkg::INDEX_W-1:0] word_index;
    logic                         word_last;
    logic [1:0]                   frame_status;
    logic [1:0]                   command_class;
    logic                         last_of_run;

    modport source (output valid, output out_kind, output out_byte, output word_index,
                    output word_last, output frame_status, output command_class,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_kind, input out_byte, input word_index,
                    input word_last, input frame_status, input command_class,
                    input last_of_run, output ready);

endinterface

// ----- design/length_prefixed_request_deframer.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_request_deframer
// Parses length-prefixed request frames one byte per request and emits word
// bytes, a frame-finished result with command class, or a close on error.
//
// Channels: i_req carries one stream byte and a new_connection flag per
// request; o_rsp carries results. Each request makes zero, one or two results.
// A request's first result is registered into the result queue and, when the
// queue is empty, is visible on o_rsp in the cycle after the request is taken.
// Throughput: one request per cycle while i_req.ready is high, which depends
// only on the fill of a three-entry result queue: it is high while at most one
// result waits, so a request is taken even while a result is stalled. A request
// that makes two results (last word byte plus frame end) queues both in order.
// Reset: the parser returns to a frame header, the connection is open and the
// result queue is empty. While the receiver stalls, results stay queued in
// order and i_req.ready drops once two or more wait.
// ----------------------------------------------------------------------------
module length_prefixed_request_deframer #(
    parameter int MAX_FRAME_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lprd_in_if.sink     i_req,
    lprd_out_if.source  o_rsp
);

    localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [31:0]   MAX32    = 32'(MAX_FRAME_BYTES);
    localparam logic [31:0]   LEN32    = 32'(lprd_pkg::LEN_FIELD_BYTES);
    localparam logic [CW-1:0] LEN_CW   = CW'(lprd_pkg::LEN_FIELD_BYTES);
    localparam logic [1:0]    HDR_LAST = 2'(lprd_pkg::LEN_FIELD_BYTES - 1);
    localparam int QDEPTH = 3;

    typedef enum logic [1:0] {
        PH_FRAME_LEN,
        PH_WORD_COUNT,
        PH_WORD_LEN,
        PH_WORD_DATA
    } t_phase;

    typedef struct packed {
        t_phase        phase;
        logic [23:0]   hdr_shift;
        logic [1:0]    hdr_cnt;
        logic [CW-1:0] frame_len;
        logic [CW-1:0] bytes_used;
        logic [CW-1:0] word_total;
        logic [CW-1:0] words_left;
        logic [CW-1:0] word_bytes_left;
        logic [23:0]   first_word;
        logic [2:0]    fw_len;      // saturates at 4: only "exactly 3" matters
    } t_state;

    localparam t_state ST_RESTART = '{
        phase:           PH_FRAME_LEN,
        hdr_shift:       24'd0,
        hdr_cnt:         2'd0,
        frame_len:       '0,
        bytes_used:      '0,
        word_total:      '0,
        words_left:      '0,
        word_bytes_left: '0,
        first_word:      24'd0,
        fw_len:          3'd0
    };

    t_state r_state, n_state;
    logic   r_closed, n_closed;
    lprd_pkg::t_result r_q [QDEPTH];
    lprd_pkg::t_result n_q [QDEPTH];
    logic [1:0] r_count, n_count;

    logic          req_acc, rsp_pop;
    logic [31:0]   hdr_val;
    logic [CW-1:0] idx;
    logic [7:0]    folded;
    logic          is_last, wb_valid, do_after, do_finish, do_fail;
    lprd_pkg::t_status fail_st;
    lprd_pkg::t_class  cls;
    lprd_pkg::t_result res_first, res_ev, res_wb;
    logic              ev_valid;
    logic [1:0]        nres, cnt_t;

    assign i_req.ready = (r_count <= 2'd1);
    assign req_acc     = i_req.valid && i_req.ready;
    assign rsp_pop     = o_rsp.valid && o_rsp.ready;

    // Parser: one request is fully decided in this block.
    always_comb begin
        n_state   = r_state;
        n_closed  = r_closed;
        hdr_val   = '0;
        idx       = '0;
        folded    = '0;
        is_last   = 1'b0;
        wb_valid  = 1'b0;
        do_after  = 1'b0;
        do_finish = 1'b0;
        do_fail   = 1'b0;
        fail_st   = lprd_pkg::STATUS_BAD;
        cls       = lprd_pkg::CLS_UNKNOWN;
        if (req_acc) begin
            if (i_req.new_connection) begin
                n_closed = 1'b0;
                n_state  = ST_RESTART;
            end
            if (!n_closed) begin
                if (n_state.phase == PH_WORD_DATA) begin
                    idx = n_state.word_total - n_state.words_left;
                    if (idx == '0) begin
                        folded = (i_req.in_byte >= 8'h41 && i_req.in_byte <= 8'h5A)
                               ? (i_req.in_byte | 8'h20) : i_req.in_byte;
                        if (n_state.fw_len < 3'd3) begin
                            n_state.first_word = {n_state.first_word[15:0], folded};
                        end
                        if (n_state.fw_len < 3'd4) begin
                            n_state.fw_len = n_state.fw_len + 3'd1;
                        end
                    end
                    n_state.bytes_used      = n_state.bytes_used + CW'(1);
                    n_state.word_bytes_left = n_state.word_bytes_left - CW'(1);
                    is_last  = (n_state.word_bytes_left == '0);
                    wb_valid = 1'b1;
                    do_after = is_last;
                end else begin
                    hdr_val = {n_state.hdr_shift, i_req.in_byte};
                    n_state.hdr_shift = hdr_val[23:0];
                    if (n_state.phase != PH_FRAME_LEN) begin
                        n_state.bytes_used = n_state.bytes_used + CW'(1);
                    end
                    if (n_state.hdr_cnt != HDR_LAST) begin
                        n_state.hdr_cnt = n_state.hdr_cnt + 2'd1;
                    end else begin
                        n_state.hdr_cnt   = 2'd0;
                        n_state.hdr_shift = 24'd0;
                        case (n_state.phase)
                            PH_FRAME_LEN: begin
                                if (hdr_val > MAX32) begin
                                    do_fail = 1'b1;
                                    fail_st = lprd_pkg::STATUS_TOO_LONG;
                                end else if (hdr_val < LEN32) begin
                                    do_fail = 1'b1;
                                end else begin
                                    n_state.frame_len  = hdr_val[CW-1:0];
                                    n_state.bytes_used = '0;
                                    n_state.phase      = PH_WORD_COUNT;
                                end
                            end
                            PH_WORD_COUNT: begin
                                if (hdr_val > MAX32) begin
                                    do_fail = 1'b1;
                                end else begin
                                    n_state.word_total = hdr_val[CW-1:0];
                                    n_state.words_left = hdr_val[CW-1:0];
                                    if (hdr_val == 32'd0) begin
                                        if (n_state.bytes_used == n_state.frame_len) begin
                                            do_finish = 1'b1;
                                        end else begin
                                            do_fail = 1'b1;
                                        end
                                    end else if ((n_state.frame_len - n_state.bytes_used)
                                                 < LEN_CW) begin
                                        do_fail = 1'b1;
                                    end else begin
                                        n_state.phase = PH_WORD_LEN;
                                    end
                                end
                            end
                            PH_WORD_LEN: begin
                                if (hdr_val > 32'(n_state.frame_len - n_state.bytes_used)) begin
                                    do_fail = 1'b1;
                                end else if (hdr_val == 32'd0) begin
                                    do_after = 1'b1;
                                end else begin
                                    n_state.word_bytes_left = hdr_val[CW-1:0];
                                    n_state.phase           = PH_WORD_DATA;
                                end
                            end
                            default: begin
                                n_state = ST_RESTART;
                            end
                        endcase
                    end
                end

                // End of a word: next word header, frame end, or an error.
                if (do_after) begin
                    n_state.words_left = n_state.words_left - CW'(1);
                    if (n_state.words_left == '0) begin
                        if (n_state.bytes_used == n_state.frame_len) begin
                            do_finish = 1'b1;
                        end else begin
                            do_fail = 1'b1;
                        end
                    end else if ((n_state.frame_len - n_state.bytes_used) < LEN_CW) begin
                        do_fail = 1'b1;
                    end else begin
                        n_state.phase     = PH_WORD_LEN;
                        n_state.hdr_shift = 24'd0;
                        n_state.hdr_cnt   = 2'd0;
                    end
                end

                if (n_state.fw_len == 3'd3) begin
                    if (n_state.word_total == CW'(2) && n_state.first_word == lprd_pkg::FW_GET) begin
                        cls = lprd_pkg::CLS_GET;
                    end else if (n_state.word_total == CW'(3)
                                 && n_state.first_word == lprd_pkg::FW_SET) begin
                        cls = lprd_pkg::CLS_SET;
                    end else if (n_state.word_total == CW'(2)
                                 && n_state.first_word == lprd_pkg::FW_DEL) begin
                        cls = lprd_pkg::CLS_DEL;
                    end
                end

                if (do_fail) begin
                    n_closed = 1'b1;
                    n_state  = ST_RESTART;
                end else if (do_finish) begin
                    n_state  = ST_RESTART;
                end
            end
        end
    end

    // Results of this request, in order: word byte first, then frame event.
    always_comb begin
        ev_valid = do_fail || do_finish;

        res_ev.kind        = do_fail ? lprd_pkg::KIND_CLOSED : lprd_pkg::KIND_FRAME_DONE;
        res_ev.data        = '0;
        res_ev.index       = '0;
        res_ev.word_last   = 1'b0;
        res_ev.status      = do_fail ? fail_st : lprd_pkg::STATUS_OK;
        res_ev.cls         = do_fail ? lprd_pkg::CLS_GET : cls;
        res_ev.last_of_run = 1'b1;

        res_wb.kind        = lprd_pkg::KIND_WORD_BYTE;
        res_wb.data        = i_req.in_byte;
        res_wb.index       = lprd_pkg::INDEX_W'(idx);
        res_wb.word_last   = is_last;
        res_wb.status      = lprd_pkg::STATUS_OK;
        res_wb.cls         = lprd_pkg::CLS_GET;
        res_wb.last_of_run = !ev_valid;

        res_first = wb_valid ? res_wb : res_ev;
        nres      = {1'b0, wb_valid} + {1'b0, ev_valid};
    end

    // Result queue: slot 0 is the head shown on o_rsp.
    always_comb begin
        n_q   = r_q;
        cnt_t = r_count;
        if (rsp_pop) begin
            n_q[0] = r_q[1];
            n_q[1] = r_q[2];
            cnt_t  = r_count - 2'd1;
        end
        for (int i = 0; i < QDEPTH; i++) begin
            if (nres != 2'd0 && 2'(i) == cnt_t) begin
                n_q[i] = res_first;
            end
            if (nres == 2'd2 && 2'(i) == 2'(cnt_t + 2'd1)) begin
                n_q[i] = res_ev;
            end
        end
        n_count = cnt_t + nres;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_RESTART;
            r_closed <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_state  <= n_state;
            r_closed <= n_closed;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_rsp.valid         = (r_count != 2'd0);
    assign o_rsp.out_kind      = r_q[0].kind;
    assign o_rsp.out_byte      = r_q[0].data;
    assign o_rsp.word_index    = r_q[0].index;
    assign o_rsp.word_last     = r_q[0].word_last;
    assign o_rsp.frame_status  = r_q[0].status;
    assign o_rsp.command_class = r_q[0].cls;
    assign o_rsp.last_of_run   = r_q[0].last_of_run;

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the length-prefixed request deframer. A short table
// of directed requests covers the length and close cases and a get command.
// Random frames follow, some with injected faults. A local parser model
// predicts each result the table does not give, and results are compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_FRAME    = 4096;
    localparam int NUM_ITEMS    = 1150;
    localparam int HOLD_AT_ITEM = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IW           = lprd_pkg::INDEX_W;

    typedef enum logic [2:0] {
        PH_LENGTH,
        PH_COUNT,
        PH_WORD_LEN,
        PH_WORD_DATA
    } t_phase;

    typedef enum int {
        PICK_GET,
        PICK_SET,
        PICK_DEL,
        PICK_RANDOM,
        PICK_BAD_COUNT
    } t_cmd_pick;

    typedef enum int {
        FAULT_NONE,
        FAULT_NOISE,
        FAULT_LEFTOVER,
        FAULT_TRUNCATED,
        FAULT_HUGE_LEN,
        FAULT_CORRUPT
    } t_fault;

    typedef struct {
        logic [7:0]        data;
        logic              new_conn;
        bit                typed;
        lprd_pkg::t_result result;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    always #1ns i_clk = ~i_clk;

    lprd_in_if  req_if ();
    lprd_out_if rsp_if ();

    length_prefixed_request_deframer #(
        .MAX_FRAME_BYTES (MAX_FRAME)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Parser model state.
    t_phase        cur_phase;
    logic [31:0]   hdr_shift;
    logic [1:0]    hdr_count;
    logic [IW-1:0] frame_len;
    logic [IW-1:0] used_bytes;
    logic [IW-1:0] word_count;
    logic [IW-1:0] words_remaining;
    logic [IW-1:0] word_remaining;
    logic [23:0]   cmd_word;
    logic [IW-1:0] cmd_len;
    bit            conn_closed;

    lprd_pkg::t_result step_results[$];
    lprd_pkg::t_result pending_results[$];
    t_dir_row          dir_rows[$];
    logic [7:0]        req_payload[$];

    int  items_sent    = 0;
    int  results_seen  = 0;
    int  word_bytes    = 0;
    int  frames_done   = 0;
    int  frames_closed = 0;
    int  mismatches    = 0;
    int  cycle_count   = 0;
    bit  hold_pending  = 1'b0;
    bit  req_burst     = 1'b0;
    bit  rsp_burst     = 1'b0;

    function automatic void restart_parse();
        cur_phase       = PH_LENGTH;
        hdr_shift       = '0;
        hdr_count       = '0;
        frame_len       = '0;
        used_bytes      = '0;
        word_count      = '0;
        words_remaining = '0;
        word_remaining  = '0;
        cmd_word        = '0;
        cmd_len         = '0;
    endfunction

    function automatic void push_result(lprd_pkg::t_kind k, logic [7:0] d,
                                        logic [IW-1:0] idx, logic wl,
                                        lprd_pkg::t_status st, lprd_pkg::t_class c);
        lprd_pkg::t_result r;
        r.kind        = k;
        r.data        = d;
        r.index       = idx;
        r.word_last   = wl;
        r.status      = st;
        r.cls         = c;
        r.last_of_run = 1'b0;
        step_results.insert(step_results.size(), r);
    endfunction

    function automatic void close_conn(lprd_pkg::t_status st);
        conn_closed = 1'b1;
        restart_parse();
        push_result(lprd_pkg::KIND_CLOSED, '0, '0, 1'b0, st, lprd_pkg::CLS_GET);
    endfunction

    function automatic void frame_done();
        lprd_pkg::t_class c;
        bit               three;
        three = (cmd_len == 3);
        c = lprd_pkg::CLS_UNKNOWN;
        if (three && word_count == 2 && cmd_word == lprd_pkg::FW_GET)
            c = lprd_pkg::CLS_GET;
        else if (three && word_count == 3 && cmd_word == lprd_pkg::FW_SET)
            c = lprd_pkg::CLS_SET;
        else if (three && word_count == 2 && cmd_word == lprd_pkg::FW_DEL)
            c = lprd_pkg::CLS_DEL;
        restart_parse();
        push_result(lprd_pkg::KIND_FRAME_DONE, '0, '0, 1'b0, lprd_pkg::STATUS_OK, c);
    endfunction

    function automatic void word_done();
        words_remaining--;
        if (words_remaining == 0) begin
            if (used_bytes == frame_len)
                frame_done();
            else
                close_conn(lprd_pkg::STATUS_BAD);
        end else if (frame_len - used_bytes < lprd_pkg::LEN_FIELD_BYTES) begin
            close_conn(lprd_pkg::STATUS_BAD);
        end else begin
            cur_phase = PH_WORD_LEN;
            hdr_shift = '0;
            hdr_count = '0;
        end
    endfunction

    // Fills step_results with what one request byte causes.
    function automatic void parse_stream_byte(logic [7:0] b, logic nc);
        logic [IW-1:0] idx;
        logic [7:0]    folded;
        logic [31:0]   v;
        step_results.delete();
        if (nc) begin
            conn_closed = 1'b0;
            restart_parse();
        end
        if (conn_closed)
            return;
        if (cur_phase == PH_WORD_DATA) begin
            idx = word_count - words_remaining;
            if (idx == 0) begin
                folded = (b >= 8'h41 && b <= 8'h5A) ? (b | 8'h20) : b;
                if (cmd_len < 3)
                    cmd_word = {cmd_word[15:0], folded};
                if (cmd_len != '1)
                    cmd_len++;
            end
            used_bytes++;
            word_remaining--;
            push_result(lprd_pkg::KIND_WORD_BYTE, b, idx, word_remaining == 0,
                        lprd_pkg::STATUS_OK, lprd_pkg::CLS_GET);
            if (word_remaining == 0)
                word_done();
        end else begin
            hdr_shift = {hdr_shift[23:0], b};
            if (cur_phase != PH_LENGTH)
                used_bytes++;
            if (hdr_count < 3) begin
                hdr_count++;
                return;
            end
            hdr_count = '0;
            v = hdr_shift;
            hdr_shift = '0;
            case (cur_phase)
                PH_LENGTH: begin
                    if (v > MAX_FRAME)
                        close_conn(lprd_pkg::STATUS_TOO_LONG);
                    else if (v < lprd_pkg::LEN_FIELD_BYTES)
                        close_conn(lprd_pkg::STATUS_BAD);
                    else begin
                        frame_len  = v[IW-1:0];
                        used_bytes = '0;
                        cur_phase  = PH_COUNT;
                    end
                end
                PH_COUNT: begin
                    if (v > MAX_FRAME) begin
                        close_conn(lprd_pkg::STATUS_BAD);
                    end else begin
                        word_count      = v[IW-1:0];
                        words_remaining = v[IW-1:0];
                        if (v == 0) begin
                            if (used_bytes == frame_len)
                                frame_done();
                            else
                                close_conn(lprd_pkg::STATUS_BAD);
                        end else if (frame_len - used_bytes < lprd_pkg::LEN_FIELD_BYTES) begin
                            close_conn(lprd_pkg::STATUS_BAD);
                        end else begin
                            cur_phase = PH_WORD_LEN;
                        end
                    end
                end
                default: begin
                    if (v > frame_len - used_bytes)
                        close_conn(lprd_pkg::STATUS_BAD);
                    else if (v == 0)
                        word_done();
                    else begin
                        word_remaining = v[IW-1:0];
                        cur_phase      = PH_WORD_DATA;
                    end
                end
            endcase
        end
    endfunction

    function automatic void add_row(logic [7:0] b, logic nc, bit typed = 1'b0,
                                    lprd_pkg::t_kind k = lprd_pkg::KIND_WORD_BYTE,
                                    lprd_pkg::t_status st = lprd_pkg::STATUS_OK,
                                    lprd_pkg::t_class c = lprd_pkg::CLS_GET);
        t_dir_row row;
        row.data               = b;
        row.new_conn           = nc;
        row.typed              = typed;
        row.result.kind        = k;
        row.result.data        = '0;
        row.result.index       = '0;
        row.result.word_last   = 1'b0;
        row.result.status      = st;
        row.result.cls         = c;
        row.result.last_of_run = 1'b1;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic void push_be32(logic [31:0] w);
        for (int k = 0; k < 4; k++)
            req_payload.insert(req_payload.size(), w[31-8*k -: 8]);
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // Offers one request and records its predicted results once it is taken.
    task automatic send_req(input logic [7:0] b, input logic nc, input bit typed = 1'b0,
                            input lprd_pkg::t_result typed_res = '0);
        int gap;
        gap = req_burst ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid          <= 1'b1;
        req_if.in_byte        <= b;
        req_if.new_connection <= nc;
        do @(posedge i_clk); while (!req_if.ready);
        items_sent++;
        if (items_sent == HOLD_AT_ITEM)
            hold_pending = 1'b1;
        parse_stream_byte(b, nc);
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last_of_run = 1'b1;
        if (typed)
            pending_results.insert(pending_results.size(), typed_res);
        else
            foreach (step_results[i])
                pending_results.insert(pending_results.size(), step_results[i]);
    endtask

    task automatic send_random_request();
        t_cmd_pick   pick;
        t_fault      fault;
        logic [23:0] cmd;
        logic [31:0] frame_length;
        logic [31:0] bad_count;
        logic [7:0]  wb;
        int          n_words;
        int          wlen;
        int          extra;
        int          r;
        int          k;
        logic        start_nc;

        req_payload.delete();
        pick = t_cmd_pick'($urandom_range(0, 4));
        case (pick)
            PICK_GET: begin
                n_words = 2;
                cmd = lprd_pkg::FW_GET;
            end
            PICK_SET: begin
                n_words = 3;
                cmd = lprd_pkg::FW_SET;
            end
            PICK_DEL: begin
                n_words = 2;
                cmd = lprd_pkg::FW_DEL;
            end
            PICK_RANDOM: begin
                n_words = $urandom_range(0, 5);
                cmd = 24'($urandom);
            end
            default: begin
                n_words = $urandom_range(0, 4);
                r = $urandom_range(0, 2);
                cmd = (r == 0) ? lprd_pkg::FW_GET :
                      (r == 1) ? lprd_pkg::FW_SET : lprd_pkg::FW_DEL;
            end
        endcase

        push_be32(n_words);
        for (int i = 0; i < n_words; i++) begin
            if (i == 0 && pick != PICK_RANDOM)
                wlen = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 4) : 3;
            else if ($urandom_range(0, 19) == 0)
                wlen = $urandom_range(7, 120);
            else
                wlen = $urandom_range(0, 6);
            push_be32(wlen);
            for (int j = 0; j < wlen; j++) begin
                if (i == 0 && pick != PICK_RANDOM && j < 3) begin
                    wb = cmd[23-8*j -: 8];
                    // Clearing bit 5 turns the lower-case letter to upper case.
                    if ($urandom_range(0, 1) == 1)
                        wb = wb & 8'hDF;
                end else begin
                    wb = 8'($urandom_range(0, 255));
                end
                req_payload.insert(req_payload.size(), wb);
            end
        end

        frame_length = req_payload.size();
        extra = 0;
        r = $urandom_range(0, 11);
        fault = (r < 7) ? FAULT_NONE : t_fault'(r - 6);
        case (fault)
            FAULT_LEFTOVER: begin
                extra = $urandom_range(1, 3);
                frame_length = frame_length + extra;
            end
            FAULT_TRUNCATED: frame_length = frame_length - $urandom_range(1, 4);
            FAULT_HUGE_LEN: begin
                if ($urandom_range(0, 1) == 1)
                    frame_length = MAX_FRAME + $urandom_range(1, 8);
                else
                    frame_length = $urandom;
            end
            FAULT_CORRUPT: begin
                if ($urandom_range(0, 1) == 1) begin
                    bad_count = $urandom_range(MAX_FRAME + 1, 32'h0001_FFFF);
                    for (int j = 0; j < 4; j++)
                        req_payload[j] = bad_count[31-8*j -: 8];
                end else begin
                    k = $urandom_range(0, req_payload.size() - 1);
                    req_payload[k] = req_payload[k] ^ (8'h01 << $urandom_range(0, 7));
                end
            end
            default: ;
        endcase

        req_burst = ($urandom_range(0, 3) == 0);
        if (fault == FAULT_NOISE)
            repeat ($urandom_range(1, 8))
                send_req(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);

        // A closed or half-parsed connection needs a new one to resync.
        start_nc = conn_closed || cur_phase != PH_LENGTH || hdr_count != 0 ||
                   $urandom_range(0, 3) == 0;
        for (int j = 0; j < 4; j++)
            send_req(frame_length[31-8*j -: 8], (j == 0) ? start_nc : 1'b0);
        foreach (req_payload[j])
            send_req(req_payload[j], $urandom_range(0, 299) == 0);
        repeat (extra)
            send_req(8'($urandom_range(0, 255)), 1'b0);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off, and the comparison.
    initial begin
        lprd_pkg::t_result want;
        int                gap;
        rsp_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                gap = HOLD_CYCLES;
            end else begin
                gap = rsp_burst ? 0 : $urandom_range(0, 3);
            end
            if (gap > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
            results_seen++;
            if ($urandom_range(0, 39) == 0)
                rsp_burst = !rsp_burst;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got kind %0d byte %02h",
                         $time, rsp_if.out_kind, rsp_if.out_byte);
            end else begin
                want = pending_results.pop_front();
                check_field("out_kind", 16'(want.kind), 16'(rsp_if.out_kind));
                check_field("out_byte", 16'(want.data), 16'(rsp_if.out_byte));
                check_field("word_index", 16'(want.index), 16'(rsp_if.word_index));
                check_field("word_last", 16'(want.word_last), 16'(rsp_if.word_last));
                check_field("frame_status", 16'(want.status), 16'(rsp_if.frame_status));
                check_field("command_class", 16'(want.cls), 16'(rsp_if.command_class));
                check_field("last_of_run", 16'(want.last_of_run), 16'(rsp_if.last_of_run));
                case (want.kind)
                    lprd_pkg::KIND_WORD_BYTE:  word_bytes++;
                    lprd_pkg::KIND_FRAME_DONE: frames_done++;
                    default:                   frames_closed++;
                endcase
            end
        end
    end

    initial begin
        i_rst_n               <= 1'b0;
        req_if.valid          <= 1'b0;
        req_if.in_byte        <= '0;
        req_if.new_connection <= 1'b0;
        conn_closed = 1'b0;
        restart_parse();

        // Length above the maximum, then a byte dropped while closed.
        add_row(8'h00, 1'b1);
        add_row(8'h00, 1'b0);
        add_row(8'h10, 1'b0);
        add_row(8'h01, 1'b0, 1'b1, lprd_pkg::KIND_CLOSED, lprd_pkg::STATUS_TOO_LONG,
                lprd_pkg::CLS_GET);
        add_row(8'hFF, 1'b0);
        // Frame shorter than the word count field.
        add_row(8'h00, 1'b1);
        add_row(8'h00, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h03, 1'b0, 1'b1, lprd_pkg::KIND_CLOSED, lprd_pkg::STATUS_BAD,
                lprd_pkg::CLS_GET);
        // Mixed-case get with an empty second word.
        add_row(8'h00, 1'b1);
        add_row(8'h00, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h0F, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h02, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h03, 1'b0);
        add_row(8'h47, 1'b0);
        add_row(8'h65, 1'b0);
        add_row(8'h54, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h00, 1'b0, 1'b1, lprd_pkg::KIND_FRAME_DONE, lprd_pkg::STATUS_OK,
                lprd_pkg::CLS_GET);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_req(dir_rows[i].data, dir_rows[i].new_conn, dir_rows[i].typed,
                     dir_rows[i].result);
        while (items_sent < NUM_ITEMS)
            send_random_request();
        req_if.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests and checked %0d results: %0d word bytes, %0d frames done,",
                 items_sent, results_seen, word_bytes, frames_done);
        $display("%0d closes, across directed cases, faulted random frames and a long stall.",
                 frames_closed);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/lprd_pkg.sv
design/lprd_in_if.sv
design/lprd_out_if.sv
design/length_prefixed_request_deframer.sv
sim/tb_top.sv
